/* rtl/dia_pkg.sv */
// ----------------------------------------------------------------------------
// dia_pkg
// Shared types and codes of the device ID allocator.
// ----------------------------------------------------------------------------
package dia_pkg;

    localparam int ID_W   = 16;
    localparam int FUNC_W = 3;
    localparam int SIZE_W = 2;
    localparam int STAT_W = 3;
    localparam int BIT_W  = 6;
    localparam int WORD_W = ID_W - BIT_W;
    localparam int MAP_W  = 1 << BIT_W;

    localparam logic [ID_W-1:0] SHORT_ID_LIMIT = 16'd255;

    localparam logic [FUNC_W-1:0] F_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] F_CLAIM   = 3'd1;
    localparam logic [FUNC_W-1:0] F_RELEASE = 3'd2;
    localparam logic [FUNC_W-1:0] F_LOOKUP  = 3'd3;
    localparam logic [FUNC_W-1:0] F_JOIN    = 3'd4;
    localparam logic [FUNC_W-1:0] F_INUSE   = 3'd5;

    localparam logic [SIZE_W-1:0] SZ_8       = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_16      = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_INVALID = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNSUP   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_USED    = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTUSED = 3'd5;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic op_rd;
        logic op_exec;
        logic scan_init;
        logic scan_rd;
        logic scan_eval;
    } dia_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic done;
    } dia_sts_t;

endpackage

/* rtl/dia_if.sv */
// ----------------------------------------------------------------------------
// dia_req_if / dia_rsp_if
// Request and response channels of the device ID allocator.
// ----------------------------------------------------------------------------
interface dia_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] id_value;
    logic [1:0]  size_code;

    modport source (output valid, output func, output id_value, output size_code,
                    input ready);
    modport sink   (input valid, input func, input id_value, input size_code,
                    output ready);
endinterface

interface dia_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] id_out;
    logic [1:0]  size_out;
    logic        in_use;

    modport source (output valid, output status, output id_out, output size_out,
                    output in_use, input ready);
    modport sink   (input valid, input status, input id_out, input size_out,
                    input in_use, output ready);
endinterface

/* rtl/dia_ctrl.sv */
// ----------------------------------------------------------------------------
// dia_ctrl
// Sequencer: clearing pass, operand read/execute and free-map scan.
// ----------------------------------------------------------------------------
module dia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dia_pkg::dia_sts_t sts,
    output dia_pkg::dia_cmd_t cmd
);
    import dia_pkg::*;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ORD   = 3'd2;
    localparam logic [2:0] S_OEX   = 3'd3;
    localparam logic [2:0] S_SINIT = 3'd4;
    localparam logic [2:0] S_SRD   = 3'd5;
    localparam logic [2:0] S_SEV   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.is_alloc ? S_SINIT : S_ORD;
                end
            end
            S_ORD:
            begin
                cmd.op_rd  = 1'b1;
                state_next = S_OEX;
            end
            S_OEX:
            begin
                cmd.op_exec = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_SINIT:
            begin
                cmd.scan_init = 1'b1;
                if (sts.done)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SEV;
            end
            S_SEV:
            begin
                cmd.scan_eval = 1'b1;
                if (sts.done)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_SRD;
            end
            default:
                state_next = S_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* rtl/dia_datapath.sv */
// ----------------------------------------------------------------------------
// dia_datapath
// Free map, size tag store, next-fit scan and result register.
// ----------------------------------------------------------------------------
module dia_datapath #(
    parameter int LONG_ID_LIMIT = 65535
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dia_pkg::dia_cmd_t           cmd,
    output dia_pkg::dia_sts_t           sts,
    input  logic [dia_pkg::FUNC_W-1:0]  func,
    input  logic [dia_pkg::ID_W-1:0]    id_value,
    input  logic [dia_pkg::SIZE_W-1:0]  size_code,
    output logic [dia_pkg::STAT_W-1:0]  status,
    output logic [dia_pkg::ID_W-1:0]    id_out,
    output logic [dia_pkg::SIZE_W-1:0]  size_out,
    output logic                        in_use
);
    import dia_pkg::*;

    localparam logic [ID_W-1:0]   LONG_LIM = LONG_ID_LIMIT[ID_W-1:0];
    localparam logic [WORD_W-1:0] LONG_WD  = LONG_LIM[ID_W-1:BIT_W];
    localparam logic [BIT_W-1:0]  LONG_BT  = LONG_LIM[BIT_W-1:0];
    localparam logic [WORD_W-1:0] SHORT_WD = SHORT_ID_LIMIT[ID_W-1:BIT_W];
    localparam logic [BIT_W-1:0]  SHORT_BT = SHORT_ID_LIMIT[BIT_W-1:0];

    // bit set = taken; tags are only used for taken IDs
    logic [MAP_W-1:0]  fmap [0:(1<<WORD_W)-1];
    logic [SIZE_W-1:0] tags [0:(1<<ID_W)-1];

    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg, next_reg, lo_reg, hi_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [WORD_W-1:0] word_reg, clr_reg;
    logic              pass_reg;
    logic [MAP_W-1:0]  map_rd_reg;
    logic [SIZE_W-1:0] tag_rd_reg;
    logic [STAT_W-1:0] st_reg;
    logic [ID_W-1:0]   ido_reg;
    logic [SIZE_W-1:0] szo_reg;
    logic              iu_reg;

    logic              res_ld;
    logic [STAT_W-1:0] res_st;
    logic [ID_W-1:0]   res_id;
    logic [SIZE_W-1:0] res_sz;
    logic              res_iu;

    logic              map_we;
    logic [WORD_W-1:0] map_wa;
    logic [MAP_W-1:0]  map_wd;
    logic              tag_we;
    logic [SIZE_W-1:0] tag_wd;
    logic [ID_W-1:0]   tag_wa;
    logic [MAP_W-1:0]  clr_pat;

    logic              taken;
    logic [STAT_W-1:0] rchk;
    logic [ID_W-1:0]   upb;
    logic [ID_W-1:0]   hm1;
    logic [MAP_W-1:0]  mlo, mhi, avail;
    logic [BIT_W-1:0]  first;
    logic [ID_W-1:0]   hit_id;
    logic              next_ld, scan_ld;
    logic [ID_W-1:0]   next_val, lo_val, hi_val;
    logic [WORD_W-1:0] word_val;
    logic              pass_val;
    logic              done;

    assign status   = st_reg;
    assign id_out   = ido_reg;
    assign size_out = szo_reg;
    assign in_use   = iu_reg;

    assign sts.clr_last = (clr_reg == {WORD_W{1'b1}});
    assign sts.is_alloc = (func == F_ALLOC);
    assign sts.done     = done;

    always_comb
    begin
        clr_pat = '0;
        if (clr_reg == '0)
            clr_pat[0] = 1'b1;
        if (clr_reg == SHORT_WD)
            clr_pat[SHORT_BT] = 1'b1;
        if (clr_reg == LONG_WD)
            clr_pat[LONG_BT] = 1'b1;
    end

    assign taken = map_rd_reg[id_reg[BIT_W-1:0]];
    assign upb   = (size_reg == SZ_8) ? SHORT_ID_LIMIT : LONG_LIM;
    assign hm1   = hi_reg - 16'd1;

    always_comb
    begin
        if (id_reg == '0 || id_reg == SHORT_ID_LIMIT)
            rchk = ST_RANGE;
        else if (size_reg == SZ_8)
            rchk = (id_reg > SHORT_ID_LIMIT) ? ST_RANGE : ST_OK;
        else if (size_reg == SZ_16)
            rchk = (id_reg >= LONG_LIM) ? ST_RANGE : ST_OK;
        else
            rchk = ST_UNSUP;
    end

    // candidate bits of the current word within [lo, hi)
    always_comb
    begin
        mlo = (word_reg == lo_reg[ID_W-1:BIT_W]) ? ({MAP_W{1'b1}} << lo_reg[BIT_W-1:0])
                                                 : {MAP_W{1'b1}};
        mhi = (word_reg == hm1[ID_W-1:BIT_W])
              ? ({MAP_W{1'b1}} >> (6'd63 - hm1[BIT_W-1:0])) : {MAP_W{1'b1}};
        avail = ~map_rd_reg & mlo & mhi;
        first = '0;
        for (int b = MAP_W - 1; b >= 0; b--)
        begin
            if (avail[b])
                first = BIT_W'(b);
        end
        hit_id = {word_reg, first};
    end

    always_comb
    begin
        res_ld   = 1'b0;
        res_st   = ST_OK;
        res_id   = '0;
        res_sz   = SZ_INVALID;
        res_iu   = 1'b0;
        map_we   = 1'b0;
        map_wa   = id_reg[ID_W-1:BIT_W];
        map_wd   = map_rd_reg;
        tag_we   = 1'b0;
        tag_wa   = id_reg;
        tag_wd   = size_reg;
        next_ld  = 1'b0;
        next_val = hit_id + 16'd1;
        scan_ld  = 1'b0;
        lo_val   = lo_reg;
        hi_val   = hi_reg;
        word_val = word_reg + 10'd1;
        pass_val = pass_reg;
        done     = 1'b0;

        if (cmd.op_exec)
        begin
            res_ld = 1'b1;
            if (func_reg == F_LOOKUP)
            begin
                if (id_reg == '0 || id_reg == SHORT_ID_LIMIT || id_reg >= LONG_LIM)
                    res_st = ST_RANGE;
                else if (taken)
                begin
                    res_id = id_reg;
                    res_sz = tag_rd_reg;
                end
                else
                    res_st = ST_NOTUSED;
            end
            else if (func_reg > F_INUSE || func_reg == F_ALLOC)
                res_st = ST_UNSUP;
            else if (rchk != ST_OK)
                res_st = rchk;
            else
            begin
                res_id = id_reg;
                res_sz = size_reg;
                case (func_reg)
                    F_CLAIM:
                    begin
                        if (!taken)
                        begin
                            map_we = 1'b1;
                            map_wd[id_reg[BIT_W-1:0]] = 1'b1;
                            tag_we = 1'b1;
                        end
                        else
                        begin
                            res_st = ST_USED;
                            res_id = '0;
                            res_sz = SZ_INVALID;
                        end
                    end
                    F_RELEASE:
                    begin
                        if (taken)
                        begin
                            map_we = 1'b1;
                            map_wd[id_reg[BIT_W-1:0]] = 1'b0;
                        end
                        else
                        begin
                            res_st = ST_NOTUSED;
                            res_id = '0;
                            res_sz = SZ_INVALID;
                        end
                    end
                    F_JOIN:
                    begin
                        if (!taken)
                        begin
                            map_we = 1'b1;
                            map_wd[id_reg[BIT_W-1:0]] = 1'b1;
                            tag_we = 1'b1;
                        end
                    end
                    default:
                        res_iu = taken;
                endcase
            end
        end

        if (cmd.scan_init)
        begin
            scan_ld = 1'b1;
            if (size_reg != SZ_8 && size_reg != SZ_16)
            begin
                done   = 1'b1;
                res_ld = 1'b1;
                res_st = ST_UNSUP;
            end
            else if (next_reg < upb)
            begin
                pass_val = 1'b0;
                lo_val   = next_reg;
                hi_val   = upb;
                word_val = next_reg[ID_W-1:BIT_W];
            end
            else
            begin
                pass_val = 1'b1;
                lo_val   = 16'd1;
                hi_val   = upb;
                word_val = '0;
            end
        end

        if (cmd.scan_eval)
        begin
            scan_ld = 1'b1;
            if (avail != '0)
            begin
                done     = 1'b1;
                res_ld   = 1'b1;
                res_id   = hit_id;
                res_sz   = size_reg;
                map_we   = 1'b1;
                map_wa   = word_reg;
                map_wd[first] = 1'b1;
                tag_we   = 1'b1;
                tag_wa   = hit_id;
                next_ld  = 1'b1;
                word_val = word_reg;
            end
            else if (word_reg == hm1[ID_W-1:BIT_W])
            begin
                // end of pass: wrap to ID 1 once, below the old start
                if (!pass_reg && next_reg > 16'd1)
                begin
                    pass_val = 1'b1;
                    lo_val   = 16'd1;
                    hi_val   = next_reg;
                    word_val = '0;
                end
                else
                begin
                    done   = 1'b1;
                    res_ld = 1'b1;
                    res_st = ST_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            fmap[clr_reg] <= clr_pat;
        else if (map_we)
            fmap[map_wa] <= map_wd;
        if (tag_we)
            tags[tag_wa] <= tag_wd;
        if (cmd.op_rd)
        begin
            map_rd_reg <= fmap[id_reg[ID_W-1:BIT_W]];
            tag_rd_reg <= tags[id_reg];
        end
        else if (cmd.scan_rd)
            map_rd_reg <= fmap[word_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            id_reg   <= id_value;
            size_reg <= size_code;
        end
        if (scan_ld)
        begin
            lo_reg   <= lo_val;
            hi_reg   <= hi_val;
            word_reg <= word_val;
            pass_reg <= pass_val;
        end
        if (res_ld)
        begin
            st_reg  <= res_st;
            ido_reg <= res_id;
            szo_reg <= res_sz;
            iu_reg  <= res_iu;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            next_reg <= 16'd1;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_reg <= clr_reg + 10'd1;
            if (next_ld)
                next_reg <= next_val;
        end
    end

endmodule

/* rtl/device_id_allocator_unit.sv */
// ----------------------------------------------------------------------------
// device_id_allocator_unit
// Next-fit device ID allocator with per-ID size tags.
// ----------------------------------------------------------------------------
// One request (func, id_value, size_code) on req gives one response
// (status, id_out, size_out, in_use) on rsp; both use valid/ready.
// Requests are handled one at a time: req.ready is high only while the
// block is idle and no response is waiting in the output register.
// Claim, release, lookup, claim-or-join and in-use each pass through an
// operand read, then update and result, before rsp.valid is raised.
// Allocate scans the free map one 64-ID word at a time (read, then
// find-first) and stops at the first free ID or when the range is exhausted.
// After reset the free map is cleared by a pass over its 1024 words, one
// word a cycle, during which no request is accepted; IDs 0, 255 and
// LONG_ID_LIMIT come out of it reserved and next-fit starts at ID 1.
// A stalled receiver holds the response in the output register and the
// block accepts no new request until it is taken.
// ----------------------------------------------------------------------------
module device_id_allocator_unit #(
    parameter int LONG_ID_LIMIT = 65535
) (
    input  logic      clk,
    input  logic      rst_n,
    dia_req_if.sink   req,
    dia_rsp_if.source rsp
);
    import dia_pkg::*;

    dia_cmd_t cmd;
    dia_sts_t sts;

    dia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dia_datapath #(
        .LONG_ID_LIMIT (LONG_ID_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (req.func),
        .id_value  (req.id_value),
        .size_code (req.size_code),
        .status    (rsp.status),
        .id_out    (rsp.id_out),
        .size_out  (rsp.size_out),
        .in_use    (rsp.in_use)
    );

endmodule

/* rtl/dia_checker.sv */
// ----------------------------------------------------------------------------
// dia_checker
// Port-level checks of the device ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dia_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [15:0] id_out,
    input logic [1:0]  size_out
);
    import dia_pkg::*;

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_no_req_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted with a response waiting");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> id_out == '0 && size_out == SZ_INVALID)
        else $error("failed response carries an ID");

    a_short_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_OK && size_out == SZ_8
        |-> id_out < SHORT_ID_LIMIT && id_out != '0)
        else $error("8-bit ID out of range");

endmodule

bind device_id_allocator_unit dia_checker u_dia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .id_out    (rsp.id_out),
    .size_out  (rsp.size_out)
);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the device ID allocator against a behavioural model of its tag
// store and next-fit search: directed and random requests, idling and stalls.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dia_pkg::*;

    localparam int LONG_LIMIT = 65535;
    localparam logic [1:0] TAG_FREE = 2'd3;
    localparam logic [FUNC_W-1:0] F_BAD = 3'd6;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id_out;
        logic [SIZE_W-1:0] size_out;
        logic              in_use;
    } id_result_t;

    logic clk;
    logic rst_n;

    dia_req_if req ();
    dia_rsp_if rsp ();

    device_id_allocator_unit #(.LONG_ID_LIMIT(LONG_LIMIT)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [1:0]  tag_store [0:65535];
    logic [15:0] scan_start;
    id_result_t  pending_results [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    longint      cycle_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic id_result_t make_result(logic [2:0] st, logic [15:0] id,
                                               logic [1:0] sz, logic iu);
        id_result_t r;
        r.status   = st;
        r.id_out   = id;
        r.size_out = sz;
        r.in_use   = iu;
        return r;
    endfunction

    function automatic logic [2:0] id_range_status(logic [15:0] v, logic [1:0] sz);
        if (v == 16'd0 || v == SHORT_ID_LIMIT)
            return ST_RANGE;
        if (sz == SZ_8)
            return (v > SHORT_ID_LIMIT) ? ST_RANGE : ST_OK;
        if (sz == SZ_16)
            return (v >= LONG_LIMIT) ? ST_RANGE : ST_OK;
        return ST_UNSUP;
    endfunction

    function automatic id_result_t next_fit_allocate(logic [1:0] sz);
        int   limit;
        int   stop;
        int   i;
        int   hit;
        hit = -1;
        if (sz == SZ_8)
            limit = int'(SHORT_ID_LIMIT);
        else if (sz == SZ_16)
            limit = LONG_LIMIT;
        else
            return make_result(ST_UNSUP, 16'd0, SZ_INVALID, 1'b0);
        for (i = int'(scan_start); i < limit && hit < 0; i++)
            if (tag_store[i] == TAG_FREE)
                hit = i;
        stop = (int'(scan_start) < limit) ? int'(scan_start) : limit;
        for (i = 1; i < stop && hit < 0; i++)
            if (tag_store[i] == TAG_FREE)
                hit = i;
        if (hit < 0)
            return make_result(ST_NONE, 16'd0, SZ_INVALID, 1'b0);
        tag_store[hit] = sz;
        scan_start = 16'(hit + 1);
        return make_result(ST_OK, 16'(hit), sz, 1'b0);
    endfunction

    function automatic id_result_t predict_id_op(logic [2:0] fn, logic [15:0] v,
                                                 logic [1:0] sz);
        logic [1:0] tag;
        logic [2:0] st;
        tag = tag_store[v];
        if (fn == F_ALLOC)
            return next_fit_allocate(sz);
        if (fn == F_LOOKUP)
        begin
            if (v == 16'd0 || v == SHORT_ID_LIMIT || v >= LONG_LIMIT)
                return make_result(ST_RANGE, 16'd0, SZ_INVALID, 1'b0);
            if (tag != TAG_FREE)
                return make_result(ST_OK, v, tag, 1'b0);
            return make_result(ST_NOTUSED, 16'd0, SZ_INVALID, 1'b0);
        end
        if (fn > F_INUSE)
            return make_result(ST_UNSUP, 16'd0, SZ_INVALID, 1'b0);
        st = id_range_status(v, sz);
        if (st != ST_OK)
            return make_result(st, 16'd0, SZ_INVALID, 1'b0);
        case (fn)
            F_CLAIM:
            begin
                if (tag != TAG_FREE)
                    return make_result(ST_USED, 16'd0, SZ_INVALID, 1'b0);
                tag_store[v] = sz;
                return make_result(ST_OK, v, sz, 1'b0);
            end
            F_RELEASE:
            begin
                if (tag == TAG_FREE)
                    return make_result(ST_NOTUSED, 16'd0, SZ_INVALID, 1'b0);
                tag_store[v] = TAG_FREE;
                return make_result(ST_OK, v, sz, 1'b0);
            end
            F_JOIN:
            begin
                if (tag == TAG_FREE)
                    tag_store[v] = sz;
                return make_result(ST_OK, v, sz, 1'b0);
            end
            default:
                return make_result(ST_OK, v, sz, tag != TAG_FREE);
        endcase
    endfunction

    // drive at the falling edge; back-to-back requests rewrite valid in one step
    task automatic send_request(logic [2:0] fn, logic [15:0] v, logic [1:0] sz);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req.valid     = 1'b1;
        req.func      = fn;
        req.id_value  = v;
        req.size_code = sz;
        do
            @(posedge clk);
        while (!req.ready);
        pending_results.push_back(predict_id_op(fn, v, sz));
        @(negedge clk);
        req.valid    = 1'b0;
        req.func     = 3'($urandom);
        req.id_value = 16'($urandom);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
    endtask

    // receiver stall pattern, changed at the falling edge
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        id_result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.id_out !== want.id_out)
                begin
                    $error("id_out: expected %0d, got %0d", want.id_out, rsp.id_out);
                    fail_count++;
                end
                if (rsp.size_out !== want.size_out)
                begin
                    $error("size_out: expected %0d, got %0d", want.size_out,
                           rsp.size_out);
                    fail_count++;
                end
                if (rsp.in_use !== want.in_use)
                begin
                    $error("in_use: expected %0d, got %0d", want.in_use, rsp.in_use);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(F_LOOKUP, 16'd0, SZ_8);
        send_request(F_LOOKUP, SHORT_ID_LIMIT, SZ_8);
        send_request(F_LOOKUP, 16'hFFFF, SZ_16);
        send_request(F_CLAIM, 16'd0, SZ_16);
        send_request(F_CLAIM, 16'd256, SZ_8);
        send_request(F_CLAIM, 16'hFFFF, SZ_16);
        send_request(F_CLAIM, 16'd254, 2'd2);
        send_request(F_JOIN, 16'd10, SZ_INVALID);
        send_request(F_ALLOC, 16'hFFFF, 2'd2);
        send_request(F_ALLOC, 16'd0, SZ_8);
        send_request(F_CLAIM, 16'hFFFE, SZ_16);
        send_request(F_CLAIM, 16'hFFFE, SZ_16);
        send_request(F_LOOKUP, 16'hFFFE, SZ_8);
        send_request(F_INUSE, 16'hFFFE, SZ_16);
        send_request(F_RELEASE, 16'hFFFE, SZ_16);
        send_request(F_RELEASE, 16'hFFFE, SZ_16);
        send_request(F_INUSE, 16'hFFFE, SZ_16);
        send_request(F_JOIN, 16'd254, SZ_8);
        send_request(F_JOIN, 16'd254, SZ_16);
        send_request(F_LOOKUP, 16'd254, SZ_16);
        send_request(F_BAD, 16'd5, SZ_8);
        send_request(3'd7, 16'd5, SZ_16);
        send_request(F_ALLOC, 16'd0, SZ_16);
    endtask

    // fill the low range so that 8-bit allocation wraps and runs dry
    task automatic test_short_exhaust();
        int i;
        for (i = 0; i < 256; i++)
            send_request(F_ALLOC, 16'($urandom), SZ_8);
        send_request(F_CLAIM, 16'd100, SZ_16);
        send_request(F_RELEASE, 16'd17, SZ_8);
        send_request(F_ALLOC, 16'd0, SZ_8);
        send_request(F_ALLOC, 16'd0, SZ_8);
    endtask

    task automatic test_random(int count);
        int         n;
        logic [2:0] fn;
        logic [15:0] v;
        logic [1:0] sz;
        for (n = 0; n < count; n++)
        begin
            fn = 3'($urandom_range(5));
            if ($urandom_range(19) == 0)
                fn = 3'($urandom_range(7));
            case ($urandom_range(5))
                0: v = 16'($urandom);
                1: v = 16'hFFFF - 16'($urandom_range(2));
                2: v = 16'(SHORT_ID_LIMIT - 2 + $urandom_range(3));
                default: v = 16'($urandom_range(300));
            endcase
            sz = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(1));
            send_request(fn, v, sz);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.func       = F_ALLOC;
        req.id_value   = 16'd0;
        req.size_code  = SZ_8;
        rsp.ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        cycle_count    = 0;
        for (int i = 0; i < 65536; i++)
            tag_store[i] = TAG_FREE;
        tag_store[0]              = SZ_8;
        tag_store[SHORT_ID_LIMIT] = SZ_8;
        tag_store[LONG_LIMIT]     = SZ_16;
        scan_start = 16'd1;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_short_exhaust();
        test_random(80);
        send_idle_pct = 88;
        test_random(80);
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        test_random(80);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        test_random(60);
        wait_drained();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
